>>> design/union_find_spanning_cost_defines.svh
// ----------------------------------------------------------------------------
// union_find_spanning_cost_defines
// Assertion macros shared by the spanning cost block.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_SPANNING_COST_DEFINES_SVH
`define UNION_FIND_SPANNING_COST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UFSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UFSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ufsc_pkg.sv
// ----------------------------------------------------------------------------
// ufsc_pkg
// Types and constants of the spanning cost block and its set store.
// ----------------------------------------------------------------------------
package ufsc_pkg;

  localparam int NODE_BITS    = 7;
  localparam int MAX_NODES    = 1 << NODE_BITS;
  localparam int RANK_BITS    = 3;
  localparam int COST_BITS    = 32;
  localparam int IN_WGT_BITS  = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam logic [31:0] WEIGHT_MASK32 =
    (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WEIGHT_BITS) - 32'd1);
  localparam logic [IN_WGT_BITS-1:0] WEIGHT_MASK = WEIGHT_MASK32[IN_WGT_BITS-1:0];

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [COST_BITS-1:0] cost_t;

  localparam rank_t RANK_MAX = '1;
  localparam cost_t COST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_RANK_A,
    ST_RANK_B,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  p_we;
    node_t p_addr;
    node_t p_data;
    logic  r_we;
    node_t r_addr;
    rank_t r_data;
  } store_wr_t;

endpackage

>>> design/ufsc_store.sv
// ----------------------------------------------------------------------------
// ufsc_store
// Parent and rank memories with per-entry valid bits; an invalid entry reads
// as its own root with rank zero.
// ----------------------------------------------------------------------------
module ufsc_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr_i,
  input  ufsc_pkg::node_t     node_count_i,
  input  ufsc_pkg::node_t     rd_addr_i,
  input  ufsc_pkg::store_wr_t wr_i,
  output ufsc_pkg::node_t     parent_o,
  output ufsc_pkg::rank_t     rank_o
);

  ufsc_pkg::node_t parent_mem [ufsc_pkg::MAX_NODES];
  ufsc_pkg::rank_t rank_mem   [ufsc_pkg::MAX_NODES];

  logic [ufsc_pkg::MAX_NODES-1:0] pvalid_r, pvalid_nxt;
  logic [ufsc_pkg::MAX_NODES-1:0] rvalid_r, rvalid_nxt;

  ufsc_pkg::node_t rd_addr_r;
  ufsc_pkg::node_t parent_rd_r;
  ufsc_pkg::rank_t rank_rd_r;

  always_comb begin
    pvalid_nxt = pvalid_r;
    rvalid_nxt = rvalid_r;
    if (clr_i) begin
      for (int i = 0; i < ufsc_pkg::MAX_NODES; i++) begin
        if (i <= int'(node_count_i)) begin
          pvalid_nxt[i] = 1'b0;
          rvalid_nxt[i] = 1'b0;
        end
      end
    end
    if (wr_i.p_we) pvalid_nxt[wr_i.p_addr] = 1'b1;
    if (wr_i.r_we) rvalid_nxt[wr_i.r_addr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= '0;
      rvalid_r <= '0;
    end else begin
      pvalid_r <= pvalid_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.p_we) parent_mem[wr_i.p_addr] <= wr_i.p_data;
    if (wr_i.r_we) rank_mem[wr_i.r_addr] <= wr_i.r_data;
    parent_rd_r <= parent_mem[rd_addr_i];
    rank_rd_r   <= rank_mem[rd_addr_i];
    rd_addr_r   <= rd_addr_i;
  end

  // never-written entries fall back to their reset value
  assign parent_o = pvalid_r[rd_addr_r] ? parent_rd_r : rd_addr_r;
  assign rank_o   = rvalid_r[rd_addr_r] ? rank_rd_r : '0;

endmodule

>>> design/union_find_spanning_cost.sv
// ----------------------------------------------------------------------------
// union_find_spanning_cost
// Takes weight-ordered edges one at a time and keeps a disjoint-set forest
// (union by rank, full path compression) plus a saturating 32-bit cost. Each
// edge returns joined, the running total_cost and bad_node. An edge with an
// endpoint above node_count goes straight to its result; otherwise both
// endpoints are walked to their roots with their paths compressed, and the
// two roots are merged unless both ends already share a set. The path length
// from each endpoint to its root is at most 7 under union by rank, though a
// start that clears only part of a linked forest can leave longer paths
// behind. The walk goes through the single read port of the parent store:
// every hop is one read turn and every compression is a read turn and a
// write turn. Start clears the nodes 0..node_count at once through valid
// bits, so there is no clearing pass after reset or start. The input is not
// ready again until the result has been transferred out.
// ----------------------------------------------------------------------------
`include "union_find_spanning_cost_defines.svh"

module union_find_spanning_cost (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ufsc_pkg::NODE_BITS-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_start_req,
  input  logic [ufsc_pkg::NODE_BITS-1:0]       in_node_a,
  input  logic [ufsc_pkg::NODE_BITS-1:0]       in_node_b,
  input  logic [ufsc_pkg::IN_WGT_BITS-1:0]     in_weight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_joined,
  output logic [ufsc_pkg::COST_BITS-1:0]       out_total_cost,
  output logic                                 out_bad_node
);

  ufsc_pkg::state_t state_r, state_nxt;

  ufsc_pkg::node_t node_count_r;
  ufsc_pkg::node_t a_r, a_nxt;
  ufsc_pkg::node_t b_r, b_nxt;
  ufsc_pkg::node_t cur_r, cur_nxt;
  ufsc_pkg::node_t top_r, top_nxt;
  ufsc_pkg::node_t ra_r, ra_nxt;
  ufsc_pkg::node_t rb_r, rb_nxt;
  ufsc_pkg::rank_t rka_r, rka_nxt;
  logic            side_r, side_nxt;
  logic [ufsc_pkg::IN_WGT_BITS-1:0] weight_r, weight_nxt;
  ufsc_pkg::cost_t cost_r, cost_nxt;
  logic            joined_r, joined_nxt;
  logic            bad_r, bad_nxt;

  logic                in_xfer;
  logic                bad_in;
  logic                clr;
  ufsc_pkg::node_t     rd_addr;
  ufsc_pkg::store_wr_t wr;
  ufsc_pkg::node_t     parent_rd;
  ufsc_pkg::rank_t     rank_rd;
  ufsc_pkg::node_t     hi, lo;
  logic [ufsc_pkg::COST_BITS:0] sum;

  ufsc_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr_i        (clr),
    .node_count_i (node_count_r),
    .rd_addr_i    (rd_addr),
    .wr_i         (wr),
    .parent_o     (parent_rd),
    .rank_o       (rank_rd)
  );

  assign in_ready = (state_r == ufsc_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign bad_in   = (in_node_a > node_count_r) || (in_node_b > node_count_r);
  assign clr      = in_xfer && in_start_req;

  assign out_valid      = (state_r == ufsc_pkg::ST_OUT);
  assign out_joined     = joined_r;
  assign out_bad_node   = bad_r;
  assign out_total_cost = cost_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ufsc_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = bad_in ? ufsc_pkg::ST_OUT : ufsc_pkg::ST_WALK_CHK;
      end
      ufsc_pkg::ST_WALK_CHK: begin
        if (parent_rd == cur_r) state_nxt = ufsc_pkg::ST_COMP_RD;
      end
      ufsc_pkg::ST_COMP_RD: begin
        if (cur_r != top_r) state_nxt = ufsc_pkg::ST_COMP_WR;
        else if (!side_r) state_nxt = ufsc_pkg::ST_WALK_CHK;
        else if (ra_r == top_r) state_nxt = ufsc_pkg::ST_OUT;
        else state_nxt = ufsc_pkg::ST_RANK_A;
      end
      ufsc_pkg::ST_COMP_WR: state_nxt = ufsc_pkg::ST_COMP_RD;
      ufsc_pkg::ST_RANK_A:  state_nxt = ufsc_pkg::ST_RANK_B;
      ufsc_pkg::ST_RANK_B:  state_nxt = ufsc_pkg::ST_OUT;
      ufsc_pkg::ST_OUT: begin
        if (out_ready) state_nxt = ufsc_pkg::ST_IDLE;
      end
      default: state_nxt = ufsc_pkg::ST_IDLE;
    endcase
  end

  // merge direction: the lower rank goes under; on a tie the first root goes under
  always_comb begin
    if (rka_r <= rank_rd) begin
      hi = rb_r;
      lo = ra_r;
    end else begin
      hi = ra_r;
      lo = rb_r;
    end
    sum = {1'b0, cost_r} + (ufsc_pkg::COST_BITS + 1)'(weight_r);
  end

  // datapath and store control
  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    cur_nxt    = cur_r;
    top_nxt    = top_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rka_nxt    = rka_r;
    side_nxt   = side_r;
    weight_nxt = weight_r;
    cost_nxt   = cost_r;
    joined_nxt = joined_r;
    bad_nxt    = bad_r;
    rd_addr    = cur_r;
    wr         = '0;
    case (state_r)
      ufsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          a_nxt      = in_node_a;
          b_nxt      = in_node_b;
          cur_nxt    = in_node_a;
          side_nxt   = 1'b0;
          weight_nxt = in_weight & ufsc_pkg::WEIGHT_MASK;
          joined_nxt = 1'b0;
          bad_nxt    = bad_in;
          rd_addr    = in_node_a;
          if (in_start_req) cost_nxt = '0;
        end
      end
      ufsc_pkg::ST_WALK_CHK: begin
        if (parent_rd == cur_r) begin
          top_nxt = cur_r;
          cur_nxt = side_r ? b_r : a_r;
        end else begin
          cur_nxt = parent_rd;
          rd_addr = parent_rd;
        end
      end
      ufsc_pkg::ST_COMP_RD: begin
        if (cur_r == top_r) begin
          if (!side_r) begin
            ra_nxt   = top_r;
            side_nxt = 1'b1;
            cur_nxt  = b_r;
            rd_addr  = b_r;
          end else begin
            rb_nxt  = top_r;
            rd_addr = ra_r;
          end
        end
      end
      ufsc_pkg::ST_COMP_WR: begin
        // point the node at its root, advance up the old path
        wr.p_we   = 1'b1;
        wr.p_addr = cur_r;
        wr.p_data = top_r;
        cur_nxt   = parent_rd;
      end
      ufsc_pkg::ST_RANK_A: begin
        rka_nxt = rank_rd;
        rd_addr = rb_r;
      end
      ufsc_pkg::ST_RANK_B: begin
        wr.p_we   = 1'b1;
        wr.p_addr = lo;
        wr.p_data = hi;
        if ((rka_r == rank_rd) && (rank_rd != ufsc_pkg::RANK_MAX)) begin
          wr.r_we   = 1'b1;
          wr.r_addr = hi;
          wr.r_data = rank_rd + ufsc_pkg::rank_t'(1);
        end
        cost_nxt   = sum[ufsc_pkg::COST_BITS] ? ufsc_pkg::COST_MAX
                                              : sum[ufsc_pkg::COST_BITS-1:0];
        joined_nxt = 1'b1;
      end
      ufsc_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ufsc_pkg::ST_IDLE;
      node_count_r <= '1;
      cost_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cost_r  <= cost_nxt;
      if (cfg_we) node_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    top_r    <= top_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    rka_r    <= rka_nxt;
    side_r   <= side_nxt;
    weight_r <= weight_nxt;
    joined_r <= joined_nxt;
    bad_r    <= bad_nxt;
  end

  `UFSC_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input ready while a result is pending")
  `UFSC_ASSERT_NOW(a_bad_not_joined, out_valid && out_bad_node, !out_joined, "ignored edge joined")
  `UFSC_ASSERT_NOW(a_merge_roots, state_r == ufsc_pkg::ST_RANK_B, ra_r != rb_r, "merge of one root")
  `UFSC_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready right after transfer")

endmodule

>>> test/union_find_spanning_cost_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// union_find_spanning_cost_test
// Self-checking bench for the spanning cost block. Edges go in through the
// input channel and a scoreboard keeps its own disjoint-set forest (union by
// rank, full path compression, saturating cost) to predict joined,
// total_cost and bad_node. A directed run covers the range limits, repeated
// and same-set edges, out-of-range endpoints and partial clears. Random runs
// of start-led edge sequences follow, under several node counts, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module union_find_spanning_cost_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_EDGES  = 135;

  typedef logic [ufsc_pkg::IN_WGT_BITS-1:0] weight_t;

  typedef struct packed {
    logic            joined;
    ufsc_pkg::cost_t total;
    logic            bad;
  } edge_result_t;

  class spanning_cost_board;
    ufsc_pkg::node_t parent_of[ufsc_pkg::MAX_NODES];
    ufsc_pkg::rank_t rank_of[ufsc_pkg::MAX_NODES];
    ufsc_pkg::cost_t cost_sum;
    ufsc_pkg::node_t last_node;
    edge_result_t    expected_q[$];
    int              errors;

    function void power_on();
      for (int i = 0; i < ufsc_pkg::MAX_NODES; i++) begin
        parent_of[i] = ufsc_pkg::node_t'(i);
        rank_of[i]   = '0;
      end
      cost_sum  = '0;
      last_node = ufsc_pkg::node_t'(ufsc_pkg::MAX_NODES - 1);
      errors    = 0;
      expected_q.delete();
    endfunction

    function void set_node_count(ufsc_pkg::node_t value);
      last_node = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // entries above the node count keep whatever they held
    function void clear_sets();
      for (int i = 0; i <= int'(last_node); i++) begin
        parent_of[i] = ufsc_pkg::node_t'(i);
        rank_of[i]   = '0;
      end
      cost_sum = '0;
    endfunction

    function ufsc_pkg::node_t root_of(ufsc_pkg::node_t n);
      ufsc_pkg::node_t top;
      ufsc_pkg::node_t cur;
      ufsc_pkg::node_t up;
      top = n;
      for (int hops = 0; hops < ufsc_pkg::MAX_NODES; hops++) begin
        if (parent_of[top] == top) break;
        top = parent_of[top];
      end
      // point every node on the walk straight at the root
      cur = n;
      for (int hops = 0; hops < ufsc_pkg::MAX_NODES && cur != top; hops++) begin
        up             = parent_of[cur];
        parent_of[cur] = top;
        cur            = up;
      end
      return top;
    endfunction

    function void note_edge(logic start, ufsc_pkg::node_t a, ufsc_pkg::node_t b,
                            weight_t w);
      edge_result_t    r;
      ufsc_pkg::node_t ra;
      ufsc_pkg::node_t rb;
      ufsc_pkg::node_t hi;
      ufsc_pkg::node_t lo;
      logic [ufsc_pkg::COST_BITS:0] sum;
      r = '0;
      if (start) clear_sets();
      if (a > last_node || b > last_node) begin
        r.bad = 1'b1;
      end else begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra != rb) begin
          if (rank_of[ra] <= rank_of[rb]) begin
            hi = rb;
            lo = ra;
          end else begin
            hi = ra;
            lo = rb;
          end
          parent_of[lo] = hi;
          if (rank_of[hi] == rank_of[lo] && rank_of[hi] != ufsc_pkg::RANK_MAX) begin
            rank_of[hi] = rank_of[hi] + ufsc_pkg::rank_t'(1);
          end
          sum      = {1'b0, cost_sum} + (w & ufsc_pkg::WEIGHT_MASK);
          cost_sum = sum[ufsc_pkg::COST_BITS] ? ufsc_pkg::COST_MAX
                                              : sum[ufsc_pkg::COST_BITS-1:0];
          r.joined = 1'b1;
        end
      end
      r.total = cost_sum;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic joined, ufsc_pkg::cost_t total, logic bad);
      edge_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result joined=%0b total_cost=%0d bad_node=%0b",
                 $time, joined, total, bad);
        return;
      end
      e = expected_q.pop_front();
      if (joined !== e.joined) begin
        errors++;
        $display("%0t: joined expected %0b actual %0b", $time, e.joined, joined);
      end
      if (total !== e.total) begin
        errors++;
        $display("%0t: total_cost expected %0d actual %0d", $time, e.total, total);
      end
      if (bad !== e.bad) begin
        errors++;
        $display("%0t: bad_node expected %0b actual %0b", $time, e.bad, bad);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  ufsc_pkg::node_t cfg_data;
  logic            in_valid;
  logic            in_ready;
  logic            in_start_req;
  ufsc_pkg::node_t in_node_a;
  ufsc_pkg::node_t in_node_b;
  weight_t         in_weight;
  logic            out_valid;
  logic            out_ready;
  logic            out_joined;
  ufsc_pkg::cost_t out_total_cost;
  logic            out_bad_node;

  spanning_cost_board board;
  bit  feed_idle_on;
  bit  sink_idle_on;
  bit  hold_request;
  int  cycle_count = 0;

  union_find_spanning_cost uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_req  (in_start_req),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .in_weight     (in_weight),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_joined    (out_joined),
    .out_total_cost(out_total_cost),
    .out_bad_node  (out_bad_node)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each transfer, stall in short bursts or one long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        board.check_result(out_joined, out_total_cost, out_bad_node);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays up across back-to-back transfers; drop it only for a gap
  task automatic send_edge(logic start, ufsc_pkg::node_t a, ufsc_pkg::node_t b,
                           weight_t w);
    int gap;
    if (feed_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_node_a    <= a;
    in_node_b    <= b;
    in_weight    <= w;
    do @(posedge clk); while (!in_ready);
    board.note_edge(start, a, b, w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(ufsc_pkg::node_t value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_node_count(value);
  endtask

  task automatic run_directed();
    write_node_count(ufsc_pkg::node_t'(127));
    send_edge(1'b1, 7'd0,   7'd127, 16'h0000);
    send_edge(1'b0, 7'd127, 7'd0,   16'hFFFF);
    send_edge(1'b0, 7'd5,   7'd5,   16'h1234);
    send_edge(1'b0, 7'd1,   7'd2,   16'h5555);
    send_edge(1'b0, 7'd3,   7'd4,   16'hAAAA);
    send_edge(1'b0, 7'd2,   7'd4,   16'h00FF);
    send_edge(1'b0, 7'd6,   7'd7,   16'h0001);
    send_edge(1'b0, 7'd8,   7'd9,   16'h0002);
    send_edge(1'b0, 7'd6,   7'd8,   16'h0003);
    send_edge(1'b0, 7'd1,   7'd9,   16'hFFFF);
    send_edge(1'b0, 7'd3,   7'd7,   16'hFFFF);
    send_edge(1'b0, 7'd100, 7'd126, 16'h8000);
    drain_results();
    // clear only the low nodes; the high ones keep their links
    write_node_count(ufsc_pkg::node_t'(3));
    send_edge(1'b1, 7'd100, 7'd1,   16'h7FFF);
    send_edge(1'b0, 7'd4,   7'd0,   16'h0005);
    send_edge(1'b0, 7'd3,   7'd127, 16'h0006);
    send_edge(1'b0, 7'd3,   7'd2,   16'h000A);
    send_edge(1'b0, 7'd0,   7'd0,   16'h000B);
    drain_results();
    write_node_count(ufsc_pkg::node_t'(127));
    send_edge(1'b0, 7'd100, 7'd3,   16'h0014);
    send_edge(1'b0, 7'd126, 7'd1,   16'h001E);
    send_edge(1'b0, 7'd127, 7'd0,   16'h0028);
    drain_results();
    write_node_count(ufsc_pkg::node_t'(1));
    send_edge(1'b1, 7'd1,   7'd0,   16'h0007);
    send_edge(1'b0, 7'd2,   7'd1,   16'h0008);
    send_edge(1'b0, 7'd0,   7'd1,   16'h0009);
  endtask

  function automatic ufsc_pkg::node_t pick_node(ufsc_pkg::node_t nc);
    if ($urandom_range(0, 99) < 88) return ufsc_pkg::node_t'($urandom_range(0, int'(nc)));
    return ufsc_pkg::node_t'($urandom_range(0, ufsc_pkg::MAX_NODES - 1));
  endfunction

  // start-led edge runs in rising weight order, with a little noise
  task automatic run_phase(int phase);
    ufsc_pkg::node_t nc;
    int              sent;
    int              run_len;
    int              w_run;
    weight_t         w;
    logic            start;
    case (phase % 5)
      0:       nc = ufsc_pkg::node_t'(127);
      1:       nc = ufsc_pkg::node_t'(1);
      2:       nc = ufsc_pkg::node_t'($urandom_range(2, 15));
      3:       nc = ufsc_pkg::node_t'($urandom_range(16, 126));
      default: nc = ufsc_pkg::node_t'($urandom_range(1, 127));
    endcase
    drain_results();
    write_node_count(nc);
    feed_idle_on = (phase != 3 && phase < PHASES - 2);
    sink_idle_on = feed_idle_on;
    sent = 0;
    while (sent < PHASE_EDGES) begin
      run_len = $urandom_range(4, 2 * int'(nc) + 8);
      if (run_len > 80) run_len = 80;
      w_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30000, 65535)
                                          : $urandom_range(0, 3000);
      for (int k = 0; k <= run_len && sent < PHASE_EDGES; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          w = weight_t'($urandom_range(0, 65535));
        end else begin
          w_run = w_run + $urandom_range(0, 500);
          if (w_run > 65535) w_run = 65535;
          w = weight_t'(w_run);
        end
        start = (k == 0) || ($urandom_range(0, 49) == 0);
        if (phase == 5 && sent == 20) hold_request = 1'b1;
        send_edge(start, pick_node(nc), pick_node(nc), w);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    board = new;
    board.power_on();
    hold_request = 1'b0;
    feed_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_start_req <= 1'b0;
    in_node_a    <= '0;
    in_node_b    <= '0;
    in_weight    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      run_phase(phase);
    end
    drain_results();
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
